// ----- hdl/lgrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared types and constants for the row-streaming Game of Life generation.
// ----------------------------------------------------------------------------
`default_nettype none

package lgrs_pkg;

   localparam int unsigned RowBits     = 64;
   localparam int unsigned RowNumBits  = 12;
   localparam int unsigned WidthBits   = 7;
   localparam int unsigned CountBits   = 13;
   localparam int unsigned CsrAddrBits = 3;
   localparam int unsigned CsrDataBits = 32;
   localparam int unsigned RspDataBits = 80;

   // register indexes, decoded from paddr[2]
   localparam logic RegRowWidth = 1'b0;
   localparam logic RegRowCount = 1'b1;

   localparam logic [WidthBits-1:0] RowWidthReset = 7'd64;
   localparam logic [CountBits-1:0] RowCountReset = 13'd64;
   localparam logic [WidthBits-1:0] MinWidth      = 7'd3;
   localparam logic [CountBits-1:0] MinRows       = 13'd3;

   // neighbour counts of the cell rule
   localparam logic [3:0] CountBirth = 4'd3;
   localparam logic [3:0] CountKeep  = 4'd2;

   // which result of a pending row is produced next
   typedef enum logic [2:0] {
      PH_ROW_ABOVE = 3'b001,
      PH_ROW_LAST  = 3'b010,
      PH_ROW_FIRST = 3'b100
   } phase_type;

endpackage

`default_nettype wire

// ----- hdl/life_generation_row_stream.sv -----
// ----------------------------------------------------------------------------
// life_generation_row_stream
// One Game of Life generation on a toroidal field, one row per input beat.
// ----------------------------------------------------------------------------
//  channel | dir  | beat contents
//  req     | in   | tdata[63:0] row_cells
//  rsp     | out  | tdata[11:0] row_number, [75:12] next_cells; tlast generation_done
//  csr     | apb  | 0x0 row_width, 0x4 row_count
//
//  One row beat per cycle while req_tready is high; each beat's result passes
//  through the job register and the output register. Rows 0 and 1 give no result;
//  the last row yields three result beats, keeping req_tready low until the third.
//  Output register stalls on rsp_tready; req_tready follows it combinationally.
//  Synchronous reset clears control state and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_row_stream #(
   parameter int unsigned MAX_WIDTH = 64,
   parameter int unsigned MAX_ROWS  = 4096
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // row_cells
   input  wire  [lgrs_pkg::RowBits-1:0]         req_tdata,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // row_number, next_cells, 4 bits zero pad
   output logic [lgrs_pkg::RspDataBits-1:0]     rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic                                 rsp_tlast,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [lgrs_pkg::CsrAddrBits-1:0]     csr_paddr,
   input  wire  [lgrs_pkg::CsrDataBits-1:0]     csr_pwdata,
   output logic [lgrs_pkg::CsrDataBits-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam int unsigned RowCntW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 2;

   logic [lgrs_pkg::WidthBits-1:0] row_width_ff, row_width_in;
   logic [lgrs_pkg::CountBits-1:0] row_count_ff, row_count_in;

   logic [lgrs_pkg::RowBits-1:0] window_upper_ff, window_upper_in;
   logic [lgrs_pkg::RowBits-1:0] window_middle_ff, window_middle_in;
   logic [lgrs_pkg::RowBits-1:0] saved_first_ff, saved_first_in;
   logic [lgrs_pkg::RowBits-1:0] saved_second_ff, saved_second_in;
   logic [RowCntW-1:0]           rows_received_ff, rows_received_in;

   logic                         job_valid_ff, job_valid_in;
   logic                         job_last_ff, job_last_in;
   lgrs_pkg::phase_type          job_phase_ff, job_phase_in;
   logic [RowCntW-1:0]           job_row_ff, job_row_in;
   logic [lgrs_pkg::RowBits-1:0] job_upper_ff, job_upper_in;
   logic [lgrs_pkg::RowBits-1:0] job_middle_ff, job_middle_in;
   logic [lgrs_pkg::RowBits-1:0] job_lower_ff, job_lower_in;

   logic                            out_valid_ff, out_valid_in;
   logic                            out_last_ff, out_last_in;
   logic [lgrs_pkg::RowNumBits-1:0] out_row_ff, out_row_in;
   logic [lgrs_pkg::RowBits-1:0]    out_cells_ff, out_cells_in;

   logic [lgrs_pkg::WidthBits-1:0] width_eff;
   logic [lgrs_pkg::CountBits-1:0] rows_eff;
   logic [lgrs_pkg::RowBits-1:0]   width_mask;
   logic [lgrs_pkg::RowBits-1:0]   row_masked;
   logic [lgrs_pkg::RowBits-1:0]   op_above, op_mid, op_below;
   logic                           csr_write;
   logic                           req_accept;
   logic                           row_is_last;
   logic                           out_load;
   logic                           job_done;

   function automatic logic [lgrs_pkg::RowBits-1:0] next_row(
      input logic [lgrs_pkg::RowBits-1:0]   above,
      input logic [lgrs_pkg::RowBits-1:0]   mid,
      input logic [lgrs_pkg::RowBits-1:0]   below,
      input logic [lgrs_pkg::RowBits-1:0]   mask,
      input logic [lgrs_pkg::WidthBits-1:0] w
   );
      logic [lgrs_pkg::RowBits-1:0] a, m, b, res;
      logic [5:0] wrap_col;
      logic       al, ml, bl, ar, mr, br, wrap_right;
      logic [3:0] cnt;
      a        = above & mask;
      m        = mid & mask;
      b        = below & mask;
      wrap_col = 6'(w - 7'd1);
      res      = '0;
      for (int j = 0; j < int'(lgrs_pkg::RowBits); j++) begin
         if (j == 0) begin
            al = a[wrap_col];
            ml = m[wrap_col];
            bl = b[wrap_col];
         end else begin
            al = a[(j + 63) % 64];
            ml = m[(j + 63) % 64];
            bl = b[(j + 63) % 64];
         end
         wrap_right = (7'(j + 1) == w);
         ar = wrap_right ? a[0] : a[(j + 1) % 64];
         mr = wrap_right ? m[0] : m[(j + 1) % 64];
         br = wrap_right ? b[0] : b[(j + 1) % 64];
         cnt = 4'(al) + 4'(a[j]) + 4'(ar) + 4'(ml) + 4'(mr)
             + 4'(bl) + 4'(b[j]) + 4'(br);
         res[j] = mask[j] & ((cnt == lgrs_pkg::CountBirth)
                             | ((cnt == lgrs_pkg::CountKeep) & m[j]));
      end
      return res;
   endfunction

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      row_width_in = row_width_ff;
      row_count_in = row_count_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            lgrs_pkg::RegRowWidth: row_width_in = csr_pwdata[lgrs_pkg::WidthBits-1:0];
            lgrs_pkg::RegRowCount: row_count_in = csr_pwdata[lgrs_pkg::CountBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         lgrs_pkg::RegRowWidth: csr_prdata = 32'(row_width_ff);
         lgrs_pkg::RegRowCount: csr_prdata = 32'(row_count_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // clamped geometry
   always_comb begin
      width_eff = row_width_ff;
      if (row_width_ff < lgrs_pkg::MinWidth) width_eff = lgrs_pkg::MinWidth;
      if (32'(row_width_ff) > MAX_WIDTH) width_eff = 7'(MAX_WIDTH);
      rows_eff = row_count_ff;
      if (row_count_ff < lgrs_pkg::MinRows) rows_eff = lgrs_pkg::MinRows;
      if (32'(row_count_ff) > MAX_ROWS) rows_eff = 13'(MAX_ROWS);
      for (int j = 0; j < int'(lgrs_pkg::RowBits); j++) begin
         width_mask[j] = (7'(j) < width_eff);
      end
   end

   // handshake
   assign out_load   = job_valid_ff & (~out_valid_ff | rsp_tready);
   assign job_done   = out_load & ((job_phase_ff == lgrs_pkg::PH_ROW_FIRST) | ~job_last_ff);
   assign req_tready = ~job_valid_ff | job_done;
   assign req_accept = req_tvalid & req_tready;
   assign row_masked = req_tdata & width_mask;
   assign row_is_last = (32'(rows_received_ff) + 32'd1) >= 32'(rows_eff);

   // window and row counter
   always_comb begin
      window_upper_in  = window_upper_ff;
      window_middle_in = window_middle_ff;
      saved_first_in   = saved_first_ff;
      saved_second_in  = saved_second_ff;
      rows_received_in = rows_received_ff;
      job_upper_in     = job_upper_ff;
      job_middle_in    = job_middle_ff;
      job_lower_in     = job_lower_ff;
      job_row_in       = job_row_ff;
      job_last_in      = job_last_ff;
      job_valid_in     = job_valid_ff & ~job_done;
      job_phase_in     = job_phase_ff;
      if (out_load & ~job_done) begin
         case (job_phase_ff)
            lgrs_pkg::PH_ROW_ABOVE: job_phase_in = lgrs_pkg::PH_ROW_LAST;
            lgrs_pkg::PH_ROW_LAST:  job_phase_in = lgrs_pkg::PH_ROW_FIRST;
            default:                job_phase_in = lgrs_pkg::PH_ROW_FIRST;
         endcase
      end
      if (req_accept) begin
         if (rows_received_ff == '0) begin
            saved_first_in   = row_masked;
            window_middle_in = row_masked;
            rows_received_in = RowCntW'(1);
         end else if (rows_received_ff == RowCntW'(1)) begin
            saved_second_in  = row_masked;
            window_upper_in  = window_middle_ff;
            window_middle_in = row_masked;
            rows_received_in = RowCntW'(2);
         end else begin
            job_valid_in     = 1'b1;
            job_phase_in     = lgrs_pkg::PH_ROW_ABOVE;
            job_last_in      = row_is_last;
            job_row_in       = rows_received_ff;
            job_upper_in     = window_upper_ff;
            job_middle_in    = window_middle_ff;
            job_lower_in     = row_masked;
            window_upper_in  = window_middle_ff;
            window_middle_in = row_masked;
            rows_received_in = row_is_last ? '0 : rows_received_ff + RowCntW'(1);
         end
      end
   end

   // result stage; saved rows are stable while a job is pending
   always_comb begin
      case (job_phase_ff)
         lgrs_pkg::PH_ROW_LAST: begin
            op_above = job_middle_ff;
            op_mid   = job_lower_ff;
            op_below = saved_first_ff;
         end
         lgrs_pkg::PH_ROW_FIRST: begin
            op_above = job_lower_ff;
            op_mid   = saved_first_ff;
            op_below = saved_second_ff;
         end
         default: begin
            op_above = job_upper_ff;
            op_mid   = job_middle_ff;
            op_below = job_lower_ff;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_last_in  = out_last_ff;
      out_row_in   = out_row_ff;
      out_cells_in = out_cells_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_cells_in = next_row(op_above, op_mid, op_below, width_mask, width_eff);
         case (job_phase_ff)
            lgrs_pkg::PH_ROW_LAST: begin
               out_row_in  = lgrs_pkg::RowNumBits'(job_row_ff);
               out_last_in = 1'b0;
            end
            lgrs_pkg::PH_ROW_FIRST: begin
               out_row_in  = '0;
               out_last_in = 1'b1;
            end
            default: begin
               out_row_in  = lgrs_pkg::RowNumBits'(job_row_ff - RowCntW'(1));
               out_last_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff     <= lgrs_pkg::RowWidthReset;
         row_count_ff     <= lgrs_pkg::RowCountReset;
         window_upper_ff  <= '0;
         window_middle_ff <= '0;
         saved_first_ff   <= '0;
         saved_second_ff  <= '0;
         rows_received_ff <= '0;
         job_valid_ff     <= 1'b0;
         job_phase_ff     <= lgrs_pkg::PH_ROW_ABOVE;
         out_valid_ff     <= 1'b0;
      end else begin
         row_width_ff     <= row_width_in;
         row_count_ff     <= row_count_in;
         window_upper_ff  <= window_upper_in;
         window_middle_ff <= window_middle_in;
         saved_first_ff   <= saved_first_in;
         saved_second_ff  <= saved_second_in;
         rows_received_ff <= rows_received_in;
         job_valid_ff     <= job_valid_in;
         job_phase_ff     <= job_phase_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_last_ff   <= job_last_in;
      job_row_ff    <= job_row_in;
      job_upper_ff  <= job_upper_in;
      job_middle_ff <= job_middle_in;
      job_lower_ff  <= job_lower_in;
      out_last_ff   <= out_last_in;
      out_row_ff    <= out_row_in;
      out_cells_ff  <= out_cells_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0000, out_cells_ff, out_row_ff};

   // a job that is not the field's last row never leaves its first phase
   a_single_phase: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && !job_last_ff) |-> (job_phase_ff == lgrs_pkg::PH_ROW_ABOVE))
      else $error("non-final row job advanced past its first result");

   // the closing beat of a generation always describes row 0
   a_last_is_row0: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_row_ff == '0))
      else $error("generation_done beat not for row 0");

   // taking the last row restarts the row counter
   a_wrap_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rows_received_ff > RowCntW'(1) && row_is_last)
      |=> (rows_received_ff == '0))
      else $error("row counter did not wrap after the last row");

   // a stalled result beat is never overwritten by the job stage
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_cells_ff)))
      else $error("pending result replaced while stalled");

endmodule

`default_nettype wire
